// ===== rtl/cwt_pkg.sv =====
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types, codes and character constants of the config word tokenizer.
// ----------------------------------------------------------------------------
package cwt_pkg;

  localparam int unsigned MAX_WORD_LEN_DEF = 128;
  localparam int unsigned RES_FIFO_DEPTH   = 4;

  // Tokenizer phase codes.
  localparam logic [2:0] PhSkip    = 3'd0;
  localparam logic [2:0] PhComment = 3'd1;
  localparam logic [2:0] PhSkipEsc = 3'd2;
  localparam logic [2:0] PhWord    = 3'd3;
  localparam logic [2:0] PhWordEsc = 3'd4;
  localparam logic [2:0] PhOctal   = 3'd5;
  localparam logic [2:0] PhHex     = 3'd6;

  // Quote kinds.
  localparam logic [1:0] QkNone   = 2'd0;
  localparam logic [1:0] QkDouble = 2'd1;
  localparam logic [1:0] QkSingle = 2'd2;

  // Result kinds.
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Characters.
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowB    = 8'h62;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChLowN    = 8'h6E;
  localparam logic [7:0] ChLowR    = 8'h72;
  localparam logic [7:0] ChLowS    = 8'h73;
  localparam logic [7:0] ChLowT    = 8'h74;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit7  = 8'h37;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;

  // Decoded escape characters.
  localparam logic [7:0] EscBell = 8'h07;
  localparam logic [7:0] EscBs   = 8'h08;
  localparam logic [7:0] EscFf   = 8'h0C;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_value;
    logic       newline_before;
    logic       truncated;
    logic [6:0] word_length;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= ChDigit0) && (c <= ChDigit7);
  endfunction

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h = '0;
    if ((c >= ChDigit0) && (c <= ChDigit9)) begin
      h.valid = 1'b1;
      h.value = c[3:0];
    end else if (((c >= ChLowA) && (c <= ChLowF)) || ((c >= ChUpA) && (c <= ChUpF))) begin
      // Letters a..f and A..F share their low three bits: 1..6.
      h.valid = 1'b1;
      h.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return h;
  endfunction

endpackage

// ===== rtl/config_word_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// config_word_tokenizer_core
// Splits a byte stream into configuration words: skips white space and
// comments, decodes quotes and backslash escapes, and emits one word
// character item per kept character and an end-of-word item per word.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata                         tuser          tlast
//  s_axis   in   byte                          end of stream  -
//  m_axis   out  char, nl, trunc, length       kind           last of byte
//
//  One byte is accepted per cycle while s_axis_tready is high; its results
//  are computed in the same cycle and written into a four-entry result queue.
//  A byte gives zero, one or two results; m_axis carries one per cycle while
//  m_axis_tready is high, so a byte with two results takes two transfers.
//  s_axis_tready is high while the queue has room for two results.
//  Reset clears the tokenizer state and empties the queue.
//  A stall on m_axis holds the queue; input flows until under two entries are free.
module config_word_tokenizer_core #(
  parameter int unsigned MaxWordLen = cwt_pkg::MAX_WORD_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
  input  logic        s_axis_tuser,   // [0] end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] char_value, [8] newline_before,
                                      // [9] truncated, [16:10] word_length, zero above
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last
);
  import cwt_pkg::*;

  localparam int unsigned CntW   = $clog2(MaxWordLen + 1);
  localparam int unsigned KeptW  = (CntW > 7) ? CntW : 7;
  localparam int unsigned PtrW   = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned FillW  = $clog2(RES_FIFO_DEPTH + 1);
  localparam logic [CntW-1:0] LenMax  = CntW'(MaxWordLen);
  localparam logic [CntW-1:0] LenKeep = CntW'(MaxWordLen - 1);

  typedef struct packed {
    logic [2:0]      phase;
    logic [1:0]      quote;
    logic            nl;
    logic [CntW-1:0] cnt;
    logic [7:0]      esc;
    logic [1:0]      dig;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic again;
    logic rv;
    res_t res;
  } pass_t;

  function automatic st_t st_clear();
    st_t s;
    s.phase = PhSkip;
    s.quote = QkNone;
    s.nl    = 1'b0;
    s.cnt   = '0;
    s.esc   = '0;
    s.dig   = '0;
    return s;
  endfunction

  function automatic logic [6:0] kept_len(logic [CntW-1:0] cnt);
    logic [KeptW-1:0] k;
    k = (cnt > LenKeep) ? KeptW'(LenKeep) : KeptW'(cnt);
    return (k > KeptW'(127)) ? 7'd127 : k[6:0];
  endfunction

  // Appends one character; it is only emitted while the word has room.
  function automatic pass_t do_store(st_t s, logic [7:0] v);
    pass_t p;
    p.st             = s;
    p.again          = 1'b0;
    p.rv             = (s.cnt < LenKeep);
    p.res            = '0;
    p.res.kind       = KindChar;
    p.res.char_value = v;
    if (s.cnt < LenMax) begin
      p.st.cnt = s.cnt + CntW'(1);
    end
    return p;
  endfunction

  function automatic pass_t do_end(st_t s);
    pass_t p;
    p.st                 = st_clear();
    p.again              = 1'b0;
    p.rv                 = 1'b1;
    p.res                = '0;
    p.res.kind           = KindEnd;
    p.res.newline_before = s.nl;
    p.res.truncated      = (s.cnt >= LenMax);
    p.res.word_length    = kept_len(s.cnt);
    return p;
  endfunction

  // One pass over the byte; again asks for the byte to be handled once more.
  function automatic pass_t step(st_t s, logic [7:0] c);
    pass_t      p;
    st_t        n;
    hex_t       h;
    logic [7:0] match;
    p.st    = s;
    p.again = 1'b0;
    p.rv    = 1'b0;
    p.res   = '0;
    n       = s;
    h       = hex_decode(c);
    match   = (s.quote == QkDouble) ? ChDquote : ChSquote;
    unique case (s.phase)
      PhSkip: begin
        priority if (c == ChNewline) begin
          p.st.nl = 1'b1;
        end else if (c == ChBslash) begin
          p.st.phase = PhSkipEsc;
        end else if ((c == ChHash) || (c == ChSemi)) begin
          p.st.phase = PhComment;
        end else if (is_space(c)) begin
          p.st = s;
        end else if ((c == ChDquote) || (c == ChSquote)) begin
          p.st.quote = (c == ChDquote) ? QkDouble : QkSingle;
          p.st.cnt   = '0;
          p.st.phase = PhWord;
        end else begin
          p.st.quote = QkNone;
          p.st.cnt   = '0;
          p.st.phase = PhWord;
          p.again    = 1'b1;
        end
      end
      PhComment: begin
        if (c == ChNewline) begin
          p.st.nl    = 1'b1;
          p.st.phase = PhSkip;
        end
      end
      PhSkipEsc: begin
        if (c == ChNewline) begin
          p.st.phase = PhSkip;
        end else begin
          p.st.quote = QkNone;
          p.st.cnt   = '0;
          p.st.phase = PhWordEsc;
          p.again    = 1'b1;
        end
      end
      PhWord: begin
        priority if ((s.quote != QkNone) && (c == match)) begin
          p = do_end(s);
        end else if ((s.quote == QkNone) && (is_space(c) || (c == ChHash))) begin
          // The terminating byte is handled again as skipped text.
          p       = do_end(s);
          p.again = 1'b1;
        end else if (c == ChBslash) begin
          p.st.phase = PhWordEsc;
        end else begin
          p = do_store(s, c);
        end
      end
      PhWordEsc: begin
        n.phase = PhWord;
        unique case (c)
          ChNewline: p.st = n;
          ChLowA:    p = do_store(n, EscBell);
          ChLowB:    p = do_store(n, EscBs);
          ChLowF:    p = do_store(n, EscFf);
          ChLowN:    p = do_store(n, ChNewline);
          ChLowR:    p = do_store(n, ChCr);
          ChLowS:    p = do_store(n, ChSpace);
          ChLowT:    p = do_store(n, ChTab);
          ChLowX: begin
            n.esc   = '0;
            n.dig   = '0;
            n.phase = PhHex;
            p.st    = n;
          end
          default: begin
            if (is_octal(c)) begin
              n.esc   = {5'd0, c[2:0]};
              n.dig   = 2'd1;
              n.phase = PhOctal;
              p.st    = n;
            end else begin
              p = do_store(n, c);
            end
          end
        endcase
      end
      PhOctal: begin
        if (is_octal(c) && (s.dig < 2'd3)) begin
          n.esc = {s.esc[4:0], c[2:0]};
          n.dig = s.dig + 2'd1;
          if (n.dig == 2'd3) begin
            n.phase = PhWord;
            p       = do_store(n, n.esc);
          end else begin
            p.st = n;
          end
        end else begin
          n.phase = PhWord;
          p       = do_store(n, s.esc);
          p.again = 1'b1;
        end
      end
      PhHex: begin
        if (h.valid && (s.dig < 2'd2)) begin
          n.esc = {s.esc[3:0], h.value};
          n.dig = s.dig + 2'd1;
          if (n.dig == 2'd2) begin
            n.phase = PhWord;
            p       = do_store(n, n.esc);
          end else begin
            p.st = n;
          end
        end else begin
          n.phase = PhWord;
          p       = do_store(n, s.esc);
          p.again = 1'b1;
        end
      end
      default: begin
        p.st.phase = PhSkip;
        p.again    = 1'b1;
      end
    endcase
    return p;
  endfunction

  st_t             st_q, st_d;
  res_t            fifo_q [RES_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [FillW-1:0] fill_q;

  pass_t p1, p2, p3, pe_store, pe_end;
  logic  v1, v2, v3;
  res_t  r1, r2, r3, res0, res1;
  logic  push0, push1;
  logic  s_fire, m_fire;
  logic [1:0] n_push;

  assign s_axis_tready = (fill_q <= FillW'(RES_FIFO_DEPTH - 2));
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill_q != '0);
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // Up to three passes per byte: an escape ends, then the word ends, then
  // the terminating byte is skipped. At most two of them give a result.
  always_comb begin
    p1       = step(st_q, s_axis_tdata);
    p2       = step(p1.st, s_axis_tdata);
    p3       = step(p2.st, s_axis_tdata);
    pe_store = do_store(st_q, st_q.esc);
    pe_end   = do_end((st_q.phase == PhOctal || st_q.phase == PhHex) ? pe_store.st : st_q);
    v1 = 1'b0; v2 = 1'b0; v3 = 1'b0;
    r1 = p1.res; r2 = p2.res; r3 = p3.res;
    st_d = st_q;
    if (s_axis_tuser) begin
      st_d = st_clear();
      if (st_q.phase == PhOctal || st_q.phase == PhHex) begin
        v1 = pe_store.rv;
        r1 = pe_store.res;
        v2 = 1'b1;
        r2 = pe_end.res;
      end else if ((st_q.phase == PhWord || st_q.phase == PhWordEsc) && (st_q.cnt != '0)) begin
        v1 = 1'b1;
        r1 = pe_end.res;
      end
    end else begin
      v1 = p1.rv;
      if (!p1.again) begin
        st_d = p1.st;
      end else begin
        v2 = p2.rv;
        if (!p2.again) begin
          st_d = p2.st;
        end else begin
          v3   = p3.rv;
          st_d = p3.st;
        end
      end
    end
    res0  = v1 ? r1 : (v2 ? r2 : r3);
    res1  = (v1 && v2) ? r2 : r3;
    push0 = s_fire && (v1 || v2 || v3);
    push1 = s_fire && ((v1 && v2) || (v1 && v3) || (v2 && v3));
    res0.last = !push1;
    res1.last = 1'b1;
  end

  assign n_push    = {1'b0, push0} + {1'b0, push1};
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= st_clear();
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (s_fire) begin
        st_q <= st_d;
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (m_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q + FillW'(n_push) - FillW'(m_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push1) begin
      fifo_q[wr_ptr_nx] <= res1;
    end
  end

  res_t head;
  assign head         = fifo_q[rd_ptr_q];
  assign m_axis_tdata = {7'd0, head.word_length, head.truncated, head.newline_before,
                         head.char_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(RES_FIFO_DEPTH))
    else $error("result queue overfilled");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser) |=> (st_q.phase == PhSkip && st_q.cnt == '0 && !st_q.nl))
    else $error("state not cleared after end of stream");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cnt <= LenMax)
    else $error("character count beyond saturation");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PhOctal |-> (st_q.dig == 2'd1 || st_q.dig == 2'd2)) and
    (st_q.phase == PhHex |-> (st_q.dig == 2'd0 || st_q.dig == 2'd1)))
    else $error("escape digit count out of range");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0 |=> m_axis_tvalid)
    else $error("pushed result not presented");

endmodule
